/* design/bfrd_pkg.sv */
// Shared types and constants for the banked framebuffer rectangle engine.
// No dependencies; every other design file but bfrd_if imports this package.
package bfrd_pkg;

   // Address of one byte in the frame store. 14 bits cover the furthest
   // spill address at the largest column count (256) and bank index (31).
   localparam int FB_ADDR_W = 14;

   // Depth of the queue between the front and the back end.
   localparam int Q_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_RECT  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   // What the back end does with a queued command.
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,   // result only, no store access
      CMD_RECT  = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   status;
      logic [FB_ADDR_W-1:0]   addr;       // first byte touched
      logic [7:0]             width_m1;   // columns per bank row, minus one
      logic [4:0]             last_row;   // bank rows after the top one
      logic                   fill;
      logic [7:0]             edge_top;
      logic [7:0]             inner_top;
      logic [7:0]             edge_bot;
      logic [7:0]             inner_bot;
      logic [7:0]             pix_and;
      logic [7:0]             pix_or;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_stat_type;

endpackage

/* design/bfrd_if.sv */
// Channel interfaces: command words in, result words out.
// Standalone; valid/ready handshake, word moves when both are high.
interface bfrd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [7:0] rect_width;
   logic [7:0] rect_height;
   logic       fill_mode;
   logic       pixel_value;
   logic [8:0] byte_address;

   modport source (output valid, opcode, pos_x, pos_y, rect_width, rect_height,
                   fill_mode, pixel_value, byte_address, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, rect_width, rect_height,
                   fill_mode, pixel_value, byte_address, output ready);
endinterface

interface bfrd_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] read_data;

   modport source (output valid, status, read_data, input ready);
   modport sink   (input valid, status, read_data, output ready);
endinterface

/* design/bfrd_front.sv */
// Front end: takes command words and turns them into queued back-end commands.
// Depends on bfrd_pkg and bfrd_if.
module bfrd_front #(
   parameter int COLUMNS    = 84,
   parameter int PIXEL_ROWS = 48
) (
   bfrd_req_if.sink                req_chan,
   input  logic                    q_full,
   input  bfrd_pkg::back_stat_type stat,
   output logic                    q_push,
   output bfrd_pkg::cmd_type       q_data
);
   import bfrd_pkg::*;

   logic                 on_screen;
   logic [7:0]           bottom;
   logic [4:0]           bank_top;
   logic [4:0]           bank_bot;
   logic [2:0]           top_sh;
   logic [2:0]           bot_sh;
   logic [FB_ADDR_W-1:0] start;
   logic [7:0]           m_top, m_bot, m_top_fill, m_bot_fill;
   logic [7:0]           pix_bit;

   assign req_chan.ready = !q_full && !stat.clearing;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      on_screen = ({1'b0, req_chan.pos_x} < 9'(COLUMNS)) &&
                  ({1'b0, req_chan.pos_y} < 9'(PIXEL_ROWS));
      bottom    = req_chan.pos_y + req_chan.rect_height - 8'd1;   // wraps in 8 bits
      bank_top  = req_chan.pos_y[7:3];
      bank_bot  = bottom[7:3];
      top_sh    = req_chan.pos_y[2:0];
      bot_sh    = 3'd7 - bottom[2:0];
      start     = FB_ADDR_W'(COLUMNS) * FB_ADDR_W'(bank_top) + FB_ADDR_W'(req_chan.pos_x);
      pix_bit   = 8'h01 << top_sh;

      m_top      = 8'h01 << top_sh;
      m_bot      = 8'h80 >> bot_sh;
      m_top_fill = 8'hFF << top_sh;
      m_bot_fill = 8'hFF >> bot_sh;
      if (req_chan.fill_mode) begin
         m_top = m_top_fill;
         m_bot = m_bot_fill;
      end
      if (bank_top == bank_bot) begin
         m_top      = req_chan.fill_mode ? (m_top & m_bot) : (m_top | m_bot);
         m_top_fill = m_top_fill & m_bot_fill;
      end

      q_data           = '0;
      q_data.kind      = CMD_NONE;
      q_data.fill      = req_chan.fill_mode;
      q_data.edge_top  = m_top_fill;
      q_data.inner_top = m_top;
      q_data.edge_bot  = m_bot_fill;
      q_data.inner_bot = m_bot;

      unique case (opcode_type'(req_chan.opcode))
         OP_RECT: begin
            if (!on_screen || req_chan.rect_width == 8'd0 || req_chan.rect_height == 8'd0) begin
               q_data.status = 1'b1;
            end else begin
               q_data.kind     = CMD_RECT;
               q_data.addr     = start;
               q_data.width_m1 = req_chan.rect_width - 8'd1;
               // bottom bank wrapped above the top one: top row only
               q_data.last_row = (bank_bot > bank_top) ? (bank_bot - bank_top) : 5'd0;
            end
         end
         OP_PIXEL: begin
            if (on_screen) begin
               q_data.kind    = CMD_PIXEL;
               q_data.addr    = start;
               q_data.pix_and = req_chan.pixel_value ? 8'hFF : ~pix_bit;
               q_data.pix_or  = req_chan.pixel_value ? pix_bit : 8'h00;
            end
         end
         OP_READ: begin
            q_data.kind = CMD_READ;
            q_data.addr = FB_ADDR_W'(req_chan.byte_address);
         end
         default: begin
            q_data.kind = CMD_NONE;
         end
      endcase
   end

endmodule

/* design/bfrd_queue.sv */
// Command queue between the front and the back end.
// Depends on bfrd_pkg.
module bfrd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfrd_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output bfrd_pkg::cmd_type pop_data,
   output logic              empty
);
   import bfrd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

/* design/bfrd_back.sv */
// Back end: walks each store command over the frame store with read-modify-write,
// owns the store, the clearing pass and the result register. Depends on bfrd_pkg, bfrd_if.
module bfrd_back #(
   parameter int COLUMNS     = 84,
   parameter int STORE_BYTES = 504
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  bfrd_pkg::cmd_type       q_data,
   output logic                    q_pop,
   bfrd_rsp_if.source              rsp_chan,
   output bfrd_pkg::back_stat_type stat
);
   import bfrd_pkg::*;

   localparam int MEM_AW = $clog2(STORE_BYTES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [4:0]           row_ff;
   logic [7:0]           col_ff;
   logic [FB_ADDR_W-1:0] row_base_ff;
   logic [MEM_AW-1:0]    clr_ff;

   // second stage: byte read last cycle, modified and written back now
   logic                 s2_valid_ff, s2_last_ff, s2_read_ff, s2_range_ff;
   logic [FB_ADDR_W-1:0] s2_addr_ff;
   logic [7:0]           s2_and_ff, s2_or_ff;

   // last write, forwarded when the next byte read hits the same address
   logic                 wb_valid_ff;
   logic [FB_ADDR_W-1:0] wb_addr_ff;
   logic [7:0]           wb_data_ff;

   logic                 rsp_valid_ff, rsp_status_ff;
   logic [7:0]           rsp_data_ff;

   logic [7:0]           mem [STORE_BYTES];
   logic [7:0]           rd_data_ff;

   logic                 is_middle, is_edge, elem_last, can_load_rsp, mem_we;
   logic [FB_ADDR_W-1:0] issue_addr;
   logic [7:0]           elem_and, elem_or, cur_byte, new_byte;

   always_comb begin
      is_middle  = (row_ff != 5'd0) && (row_ff != cmd_ff.last_row);
      is_edge    = (col_ff == 8'd0) || (col_ff == cmd_ff.width_m1);
      elem_last  = (row_ff == cmd_ff.last_row) && (col_ff == cmd_ff.width_m1);
      issue_addr = row_base_ff + FB_ADDR_W'(col_ff);
      elem_and   = 8'hFF;
      elem_or    = 8'h00;
      unique case (cmd_ff.kind)
         CMD_RECT: begin
            if (row_ff == 5'd0) begin
               elem_or = is_edge ? cmd_ff.edge_top : cmd_ff.inner_top;
            end else if (is_middle) begin
               elem_and = 8'h00;
               elem_or  = 8'hFF;
            end else begin
               elem_or = is_edge ? cmd_ff.edge_bot : cmd_ff.inner_bot;
            end
         end
         CMD_PIXEL: begin
            elem_and = cmd_ff.pix_and;
            elem_or  = cmd_ff.pix_or;
         end
         CMD_READ, CMD_NONE: begin
            elem_and = 8'hFF;
            elem_or  = 8'h00;
         end
      endcase
      cur_byte     = (wb_valid_ff && wb_addr_ff == s2_addr_ff) ? wb_data_ff : rd_data_ff;
      new_byte     = (cur_byte & s2_and_ff) | s2_or_ff;
      mem_we       = s2_valid_ff && s2_range_ff && !s2_read_ff;
      can_load_rsp = !rsp_valid_ff || rsp_chan.ready;
      q_pop        = (state_ff == ST_IDLE) && !q_empty && can_load_rsp;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign stat.clearing      = (state_ff == ST_CLEAR);
   assign stat.busy          = (state_ff == ST_RUN) || (state_ff == ST_FLUSH);

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= 8'h00;
      end else if (mem_we) begin
         mem[s2_addr_ff[MEM_AW-1:0]] <= new_byte;
      end
      rd_data_ff <= mem[issue_addr[MEM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cmd_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= mem_we;
         wb_addr_ff  <= s2_addr_ff;
         wb_data_ff  <= new_byte;
         s2_valid_ff <= (state_ff == ST_RUN);

         // result register: loaded by a finishing command, else drained
         if (s2_valid_ff && s2_last_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= 1'b0;
            rsp_data_ff   <= (s2_read_ff && s2_range_ff) ? cur_byte : 8'h00;
         end else if (q_pop && q_data.kind == CMD_NONE) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= q_data.status;
            rsp_data_ff   <= 8'h00;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == MEM_AW'(STORE_BYTES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff      <= q_data;
                  row_ff      <= 5'd0;
                  col_ff      <= 8'd0;
                  row_base_ff <= q_data.addr;
                  if (q_data.kind != CMD_NONE) begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               s2_last_ff  <= elem_last;
               s2_addr_ff  <= issue_addr;
               s2_range_ff <= (issue_addr < FB_ADDR_W'(STORE_BYTES));
               s2_and_ff   <= elem_and;
               s2_or_ff    <= elem_or;
               s2_read_ff  <= (cmd_ff.kind == CMD_READ);
               if (elem_last) begin
                  state_ff <= ST_FLUSH;
               end else if (col_ff == cmd_ff.width_m1) begin
                  row_ff      <= row_ff + 5'd1;
                  col_ff      <= 8'd0;
                  row_base_ff <= row_base_ff + FB_ADDR_W'(COLUMNS);
               end else if (is_middle && !cmd_ff.fill) begin
                  col_ff <= cmd_ff.width_m1;   // outline: right edge only
               end else begin
                  col_ff <= col_ff + 8'd1;
               end
            end
            ST_FLUSH: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* design/banked_framebuffer_rect_draw_core.sv */
// Top level of the banked framebuffer rectangle engine.
// Depends on bfrd_pkg, bfrd_if, bfrd_front, bfrd_queue, bfrd_back.
//
//   channel | dir | handshake      | word carries
//   --------+-----+----------------+---------------------------------------------
//   req     | in  | valid / ready  | opcode, pos_x/y, rect size, fill, pixel, addr
//   rsp     | out | valid / ready  | status, read_data
//
// Store walk: a rejected rectangle, off-screen pixel or unused opcode is answered
//   without touching the store; an on-screen pixel or a read touches one byte.
//   A rectangle touches w bytes in the top bank row, w (fill) or 2 (outline, 1
//   when w is 1) per middle row and w in the bottom row, one byte at a time
//   through the single read-modify-write port on the frame store.
// Reset: synchronous; afterwards the store is cleared one byte a cycle, all
//   COLUMNS * ceil(PIXEL_ROWS/8) bytes (504 by default), while req.ready stays low.
// Stalls: a short command queue decouples req from the back end; the back end
//   starts a command only when the result register is free or being drained.
module banked_framebuffer_rect_draw_core #(
   parameter int COLUMNS    = 84,
   parameter int PIXEL_ROWS = 48
) (
   input  logic       clock,
   input  logic       reset,
   bfrd_req_if.sink   req_chan,
   bfrd_rsp_if.source rsp_chan
);
   import bfrd_pkg::*;

   localparam int STORE_BYTES = COLUMNS * ((PIXEL_ROWS + 7) / 8);

   cmd_type       push_word;
   cmd_type       pop_word;
   logic          q_push, q_pop, q_full, q_empty;
   back_stat_type back_stat;

   // Front: classify, precompute masks and start address.
   bfrd_front #(
      .COLUMNS    (COLUMNS),
      .PIXEL_ROWS (PIXEL_ROWS)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .stat     (back_stat),
      .q_push   (q_push),
      .q_data   (push_word)
   );

   bfrd_queue #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_word),
      .empty     (q_empty)
   );

   // Back: byte sequencer over the store, result register.
   bfrd_back #(
      .COLUMNS     (COLUMNS),
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (pop_word),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan),
      .stat     (back_stat)
   );

   // no result can appear before the clearing pass is done
   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_stat.clearing |-> !rsp_chan.valid)
      else $error("result word during clearing pass");

   // a command leaves the queue only when the result slot will be free
   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("command popped while result slot is held");

   // the back end never sits mid-command with the clearing pass active or a queue pop
   a_busy_excl_clear: assert property (@(posedge clock) disable iff (reset)
      back_stat.busy |-> !back_stat.clearing && !q_pop)
      else $error("back end busy state overlaps clear or pop");

endmodule
